FILE: rtl/core/prd_pkg.sv
// Package for the palette run-length sprite decoder.
// Holds field widths, code values, queue entry type and shadow alpha lookup.
// No dependencies.
package prd_pkg;

    localparam int CODE_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int CHAN_W   = 8;
    localparam int RUN_W    = 12;
    localparam int CFG_W    = 12;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SHADOWED   = 1'b0;
    localparam logic CFG_LINE_WIDTH = 1'b1;

    // Special code bytes
    localparam logic [CODE_W-1:0] CODE_CLEAR      = 8'd255;
    localparam logic [CODE_W-1:0] CODE_SHADOW_RUN = 8'd250;
    localparam logic [CODE_W-1:0] COUNT_LINE      = 8'd255;

    // Alpha values
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_SHADE0 = 8'(255 - 152);
    localparam logic [CHAN_W-1:0] ALPHA_SHADE1 = 8'(255 - 216);
    localparam logic [CHAN_W-1:0] ALPHA_SHADE2 = 8'(255 - 228);
    localparam logic [CHAN_W-1:0] ALPHA_SHADE3 = 8'(255 - 240);
    localparam logic [CHAN_W-1:0] ALPHA_SHADE4 = 8'(255 - 248);

    // RGB565 field masks
    localparam logic [COLOR_W-1:0] MASK5 = 16'h001F;
    localparam logic [COLOR_W-1:0] MASK6 = 16'h003F;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PIXEL,
        OP_RUN
    } op_kind_t;

    // One unit of work handed from front to back
    typedef struct packed {
        op_kind_t            kind;
        logic [CODE_W-1:0]   index;
        logic [COLOR_W-1:0]  color;
        logic [CHAN_W-1:0]   alpha;
        logic [RUN_W-1:0]    len;
    } queue_entry_t;

    // Shadow alpha for the shadow run code and the single shadow codes
    function automatic logic [CHAN_W-1:0] shade_alpha(input logic [CODE_W-1:0] code);
        logic [CHAN_W-1:0] a;
        case (code)
            8'd251:  a = ALPHA_SHADE1;
            8'd252:  a = ALPHA_SHADE2;
            8'd253:  a = ALPHA_SHADE3;
            8'd254:  a = ALPHA_SHADE4;
            default: a = ALPHA_SHADE0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/prd_front.sv
// Front end: accepts input beats, tracks the pending count and classifies work.
// Depends on prd_pkg.
module prd_front
    import prd_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4095
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [CODE_W-1:0]   s_code_byte,
    input  logic [CODE_W-1:0]   s_palette_index,
    input  logic [COLOR_W-1:0]  s_palette_color,
    input  logic                shadowed,
    input  logic [RUN_W-1:0]    line_width,
    input  logic                q_full,
    output logic                q_push,
    output queue_entry_t        q_entry
);

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_CLEAR,
        PEND_SHADOW
    } pend_t;

    pend_t           pend_reg;
    pend_t           pend_next;
    logic            accept;
    logic            has_work;
    logic [RUN_W-1:0] line_len;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Clamp the blank line length
    assign line_len = (32'(line_width) > MAX_LINE_WIDTH) ? RUN_W'(MAX_LINE_WIDTH)
                                                        : line_width;

    // Classify the beat and pick the next pending state
    always_comb begin
        pend_next     = pend_reg;
        has_work      = 1'b0;
        q_entry.kind  = OP_RUN;
        q_entry.index = s_palette_index;
        q_entry.color = s_palette_color;
        q_entry.alpha = ALPHA_CLEAR;
        q_entry.len   = RUN_W'(s_code_byte);
        if (s_func == FUNC_LOAD) begin
            q_entry.kind = OP_LOAD;
            has_work     = 1'b1;
        end else begin
            pend_next = PEND_NONE;
            case (pend_reg)
                PEND_CLEAR: begin
                    if (s_code_byte == COUNT_LINE) begin
                        q_entry.len = line_len;
                    end
                    has_work = (q_entry.len != '0);
                end
                PEND_SHADOW: begin
                    q_entry.alpha = shade_alpha(CODE_SHADOW_RUN);
                    has_work      = (s_code_byte != '0);
                end
                default: begin
                    if (s_code_byte == CODE_CLEAR) begin
                        pend_next = PEND_CLEAR;
                    end else if (shadowed && s_code_byte == CODE_SHADOW_RUN) begin
                        pend_next = PEND_SHADOW;
                    end else if (shadowed && s_code_byte > CODE_SHADOW_RUN) begin
                        q_entry.alpha = shade_alpha(s_code_byte);
                        q_entry.len   = RUN_W'(1);
                        has_work      = 1'b1;
                    end else begin
                        q_entry.kind  = OP_PIXEL;
                        q_entry.index = s_code_byte;
                        q_entry.alpha = ALPHA_OPAQUE;
                        q_entry.len   = RUN_W'(1);
                        has_work      = 1'b1;
                    end
                end
            endcase
        end
    end

    assign q_push = accept && has_work;

    // Hold the pending state, advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
        end else if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

FILE: rtl/core/prd_fifo.sv
// Short queue of work entries between front and back.
// Depends on prd_pkg.
module prd_fifo
    import prd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  queue_entry_t  push_entry,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output queue_entry_t  q_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t      slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/prd_back.sv
// Back end: palette store, palette lookup and the result register.
// Depends on prd_pkg.
module prd_back
    import prd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  queue_entry_t       q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAN_W-1:0]  m_red,
    output logic [CHAN_W-1:0]  m_green,
    output logic [CHAN_W-1:0]  m_blue,
    output logic [CHAN_W-1:0]  m_alpha,
    output logic [RUN_W-1:0]   m_run_length
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               is_pixel_reg;
    logic [CHAN_W-1:0]  alpha_reg;
    logic [RUN_W-1:0]   len_reg;
    logic [IDX_W-1:0]   addr;

    assign addr  = q_entry.index[IDX_W-1:0];
    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (q_pop) begin
            out_valid_next = (q_entry.kind != OP_LOAD);
        end
    end

    // Write palette loads, read the entry for every popped beat
    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.kind == OP_LOAD) begin
            palette_mem[addr] <= q_entry.color;
        end
        if (q_pop) begin
            rd_data_reg <= palette_mem[addr];
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            is_pixel_reg <= (q_entry.kind == OP_PIXEL);
            alpha_reg    <= q_entry.alpha;
            len_reg      <= q_entry.len;
        end
    end

    // Expand RGB565 to 8-bit channels
    assign m_valid      = out_valid_reg;
    assign m_red        = is_pixel_reg ? {5'((rd_data_reg >> 11) & MASK5), 3'b000} : '0;
    assign m_green      = is_pixel_reg ? {6'((rd_data_reg >> 5) & MASK6), 2'b00} : '0;
    assign m_blue       = is_pixel_reg ? {5'(rd_data_reg & MASK5), 3'b000} : '0;
    assign m_alpha      = alpha_reg;
    assign m_run_length = len_reg;

endmodule

FILE: rtl/core/palette_rle_sprite_decoder_top.sv
// Top level of the palette run-length sprite decoder.
// Depends on prd_pkg, prd_front, prd_fifo and prd_back.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    func, code_byte, palette_index, palette_color
//  m_       out        m_valid/m_ready    red, green, blue, alpha, run_length
//  cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// One beat per cycle sustained while m_ready keeps up; a beat's entry is written into a queue slot
// when the beat is accepted, then popped into the result register along with its registered palette read.
// The palette read port is registered; loads and lookups pass the queue in order.
// Reset is synchronous: config returns to shadowed 0, line width 64; palette stays undefined.
// s_ready drops only when the four-entry queue fills behind a stalled m_ready.
module palette_rle_sprite_decoder_top
    import prd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_LINE_WIDTH  = 4095
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [CODE_W-1:0]   s_code_byte,
    input  logic [CODE_W-1:0]   s_palette_index,
    input  logic [COLOR_W-1:0]  s_palette_color,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAN_W-1:0]   m_red,
    output logic [CHAN_W-1:0]   m_green,
    output logic [CHAN_W-1:0]   m_blue,
    output logic [CHAN_W-1:0]   m_alpha,
    output logic [RUN_W-1:0]    m_run_length,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    logic             shadowed_reg;
    logic [RUN_W-1:0] line_width_reg;
    logic             q_full;
    logic             q_push;
    queue_entry_t     push_entry;
    logic             q_pop;
    logic             q_valid;
    queue_entry_t     q_entry;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shadowed_reg   <= 1'b0;
            line_width_reg <= RUN_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SHADOWED:   shadowed_reg   <= cfg_wdata[0];
                CFG_LINE_WIDTH: line_width_reg <= cfg_wdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    prd_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_code_byte     (s_code_byte),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .shadowed        (shadowed_reg),
        .line_width      (line_width_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    prd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    prd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_run_length (m_run_length)
    );

`ifndef SYNTHESIS
    // Zero-length runs never leave the block
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_run_length != '0)
        else $error("zero-length run delivered");

    // Only palette pixels carry color
    a_rgb_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alpha != ALPHA_OPAQUE |-> m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("color on a transparent or shadow run");

    // Opaque results are single pixels
    a_opaque_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alpha == ALPHA_OPAQUE |-> m_run_length == RUN_W'(1))
        else $error("opaque result longer than one pixel");

    // No result in the first cycle out of reset
    a_reset_idle: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

FILE: sim/tb_palette_rle_sprite_decoder_top.sv
// Testbench for palette_rle_sprite_decoder_top: loads palettes, streams coded bytes, checks runs.
// A built-in predictor computes every RGBA run; results are compared field by field in order.
// Depends on prd_pkg and the RTL of the decoder only.
`timescale 1ns / 1ps

module tb_palette_rle_sprite_decoder_top;
    import prd_pkg::*;

    // One input beat: function, code byte and palette write fields
    typedef struct packed {
        logic               func;
        logic [CODE_W-1:0]  code;
        logic [CODE_W-1:0]  pidx;
        logic [COLOR_W-1:0] pcol;
    } beat_t;

    // One RGBA run as the block reports it
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [RUN_W-1:0]  len;
    } run_t;

    // What the next code byte means
    typedef enum logic [1:0] {
        AWAIT_NONE,
        AWAIT_CLEAR,
        AWAIT_SHADOW
    } count_wait_t;

    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 8;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_func = 1'b0;
    logic [CODE_W-1:0]  s_code_byte = '0;
    logic [CODE_W-1:0]  s_palette_index = '0;
    logic [COLOR_W-1:0] s_palette_color = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAN_W-1:0]  m_red;
    logic [CHAN_W-1:0]  m_green;
    logic [CHAN_W-1:0]  m_blue;
    logic [CHAN_W-1:0]  m_alpha;
    logic [RUN_W-1:0]   m_run_length;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    palette_rle_sprite_decoder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_code_byte     (s_code_byte),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_alpha         (m_alpha),
        .m_run_length    (m_run_length),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // Predictor state
    logic               shadow_mode;
    logic [CFG_W-1:0]   blank_width;
    count_wait_t        count_wait;
    logic [COLOR_W-1:0] palette [256];

    // Stimulus bookkeeping
    beat_t  beat_queue [$];
    run_t   runs_due [$];
    bit     gen_written [256];
    int     send_idle = 0;
    int     recv_idle = 0;
    int     errors = 0;
    int     beats_in = 0;
    int     runs_seen = 0;
    int     settings = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop if the block hangs
    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 30)
            $display("MISMATCH @%0t run %0d: %s", $realtime, runs_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Expected run for one accepted beat, if any
    task automatic decode_beat(input beat_t b);
        run_t               r;
        logic [COLOR_W-1:0] c;
        r = '0;
        if (b.func == FUNC_LOAD) begin
            palette[b.pidx] = b.pcol;
            return;
        end
        case (count_wait)
            AWAIT_CLEAR: begin
                // count byte of a transparent run; 255 means a whole line
                count_wait = AWAIT_NONE;
                r.alpha = ALPHA_CLEAR;
                r.len = (b.code == COUNT_LINE) ? blank_width : RUN_W'(b.code);
                if (r.len != 0) runs_due.push_back(r);
            end
            AWAIT_SHADOW: begin
                count_wait = AWAIT_NONE;
                r.alpha = ALPHA_SHADE0;
                r.len = RUN_W'(b.code);
                if (r.len != 0) runs_due.push_back(r);
            end
            default: begin
                count_wait = AWAIT_NONE;
                if (b.code == CODE_CLEAR) begin
                    count_wait = AWAIT_CLEAR;
                end else if (shadow_mode && b.code == CODE_SHADOW_RUN) begin
                    count_wait = AWAIT_SHADOW;
                end else if (shadow_mode && b.code > CODE_SHADOW_RUN) begin
                    case (b.code)
                        8'd251:  r.alpha = ALPHA_SHADE1;
                        8'd252:  r.alpha = ALPHA_SHADE2;
                        8'd253:  r.alpha = ALPHA_SHADE3;
                        default: r.alpha = ALPHA_SHADE4;
                    endcase
                    r.len = RUN_W'(1);
                    runs_due.push_back(r);
                end else begin
                    // palette lookup, RGB565 widened to 8 bits per channel
                    c = palette[b.code];
                    r.red = CHAN_W'(((c >> 11) & MASK5) << 3);
                    r.green = CHAN_W'(((c >> 5) & MASK6) << 2);
                    r.blue = CHAN_W'((c & MASK5) << 3);
                    r.alpha = ALPHA_OPAQUE;
                    r.len = RUN_W'(1);
                    runs_due.push_back(r);
                end
            end
        endcase
    endtask

    // Driver: present the next queued beat, predict on each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_beat('{s_func, s_code_byte, s_palette_index, s_palette_color});
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_func <= beat_queue[0].func;
                    s_code_byte <= beat_queue[0].code;
                    s_palette_index <= beat_queue[0].pidx;
                    s_palette_color <= beat_queue[0].pcol;
                    void'(beat_queue.pop_front());
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted run with the oldest prediction
    always @(posedge aclk) begin : monitor
        run_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (runs_due.size() == 0) begin
                    report_mismatch("run with no prediction waiting");
                end else begin
                    want = runs_due.pop_front();
                    check_field("red", m_red, want.red);
                    check_field("green", m_green, want.green);
                    check_field("blue", m_blue, want.blue);
                    check_field("alpha", m_alpha, want.alpha);
                    check_field("run_length", m_run_length, want.len);
                end
                runs_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic push_load(input logic [CODE_W-1:0] idx, input logic [COLOR_W-1:0] col);
        beat_queue.push_back('{FUNC_LOAD, CODE_W'($urandom), idx, col});
        gen_written[idx] = 1'b1;
    endtask

    // Queue a code byte; make sure its palette entry holds a color first
    task automatic push_code(input logic [CODE_W-1:0] code);
        if (code != CODE_CLEAR && !gen_written[code])
            push_load(code, COLOR_W'($urandom));
        beat_queue.push_back('{FUNC_DECODE, code, CODE_W'($urandom), COLOR_W'($urandom)});
    endtask

    // Hold until every beat is taken and every predicted run has arrived, or until the drain limit runs out
    task automatic drain();
        int waited;
        waited = 0;
        while (beat_queue.size() != 0 || s_valid) @(posedge aclk);
        while (runs_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SHADOWED) shadow_mode = data[0];
        else blank_width = data;
    endtask

    task automatic set_config(input logic sh, input logic [CFG_W-1:0] lw);
        drain();
        write_reg(CFG_SHADOWED, {(CFG_W-1)'($urandom), sh});
        write_reg(CFG_LINE_WIDTH, lw);
        settings++;
    endtask

    // Mostly well-formed runs with random content, some broken sequences
    task automatic random_beats(input int n);
        int sel;
        int cnt;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                push_load(CODE_W'($urandom), COLOR_W'($urandom));
            end else if (sel < 22) begin
                push_code(CODE_CLEAR);
                cnt = $urandom_range(99);
                if (cnt < 25) push_code(COUNT_LINE);
                else if (cnt < 35) push_code(8'd0);
                else push_code(CODE_W'($urandom_range(254)));
            end else if (sel < 32) begin
                push_code(CODE_SHADOW_RUN);
                push_code(CODE_W'($urandom));
            end else if (sel < 42) begin
                push_code(CODE_W'($urandom_range(254, 251)));
            end else if (sel < 47) begin
                // run code with a palette write wedged before its count
                push_code($urandom_range(1) ? CODE_CLEAR : CODE_SHADOW_RUN);
                push_load(CODE_W'($urandom), COLOR_W'($urandom));
                push_code(CODE_W'($urandom));
            end else if (sel < 52) begin
                push_code(CODE_W'($urandom));
            end else begin
                push_code(CODE_W'($urandom_range(254)));
            end
        end
    endtask

    initial begin : stimulus
        int mode;
        int sub;
        logic [CFG_W-1:0] lw;
        shadow_mode = 1'b0;
        blank_width = 12'd64;
        count_wait = AWAIT_NONE;
        foreach (gen_written[i]) gen_written[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme colors, every code kind, zero counts, loads mid-run
        send_idle = 33;
        recv_idle = 63;
        set_config(1'b1, 12'd4095);
        push_load(8'h00, 16'hFFFF);
        push_load(8'hFF, 16'h0000);
        push_load(8'h7E, 16'hA5A5);
        push_code(8'h00);
        push_code(8'h7E);
        push_code(CODE_CLEAR); push_code(COUNT_LINE);
        push_code(CODE_CLEAR); push_code(8'd0);
        push_code(CODE_SHADOW_RUN); push_code(8'd255);
        push_code(CODE_SHADOW_RUN); push_code(8'd0);
        push_code(8'd251); push_code(8'd252); push_code(8'd253); push_code(8'd254);
        push_code(CODE_CLEAR);
        push_load(8'h81, 16'h5A5A);
        push_code(8'd128);
        set_config(1'b0, 12'd1);
        push_code(8'd250); push_code(8'd254);
        push_code(CODE_CLEAR); push_code(COUNT_LINE);
        push_code(8'h81);
        set_config(1'b1, 12'd0);
        push_code(CODE_CLEAR); push_code(COUNT_LINE);
        push_code(CODE_SHADOW_RUN);
        push_load(8'h10, 16'h0001);
        push_code(8'd9);

        // Random: three idling modes, two register settings each
        for (mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 33 : (mode == 1) ? 63 : 0;
            recv_idle = (mode == 0) ? 63 : (mode == 1) ? 33 : 0;
            for (sub = 0; sub < 2; sub++) begin
                case (mode * 2 + sub)
                    0:       lw = 12'd4095;
                    1:       lw = 12'd1;
                    3:       lw = 12'd64;
                    5:       lw = 12'd4095;
                    default: lw = CFG_W'($urandom_range(4095, 1));
                endcase
                set_config(sub[0], lw);
                random_beats(160);
            end
        end

        drain();
        if (runs_due.size() != 0)
            report_mismatch($sformatf("%0d predicted runs never arrived", runs_due.size()));
        $display("Summary: %0d beats accepted, %0d runs checked, %0d register settings",
                 beats_in, runs_seen, settings);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/prd_pkg.sv
rtl/core/prd_front.sv
rtl/core/prd_fifo.sv
rtl/core/prd_back.sv
rtl/core/palette_rle_sprite_decoder_top.sv
sim/tb_palette_rle_sprite_decoder_top.sv
